// ----- rtl/core/rational_arithmetic_unit_assert.svh -----
`ifndef RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH
`define RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH
// Check that a condition implies a consequence on the same edge.
`define RAU_ASSERT_IMPL(label, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error("assertion failed");
// Check that a condition implies a consequence on the next edge.
`define RAU_ASSERT_NEXT(label, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error("assertion failed");
`endif

// ----- rtl/core/rau_pkg.sv -----
`timescale 1ns / 1ps
package rau_pkg;
  localparam int ValueWidth = 32;
  localparam int MagWidth = 64;
  localparam logic [1:0] CMD_ADD = 2'd0;
  localparam logic [1:0] CMD_SUB = 2'd1;
  localparam logic [1:0] CMD_MUL = 2'd2;
  localparam logic [1:0] CMD_DIV = 2'd3;
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_ZERO_DEN = 2'd1;
  localparam logic [1:0] ST_DIV_ZERO = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  // commands from controller to datapath
  typedef struct packed {
    logic load;      // capture operands
    logic mul_step;  // one shift-add multiply step
    logic add_step;  // combine cross products
    logic gcd_init;  // copy magnitudes to gcd registers
    logic gcd_step;  // one subtract/shift step of binary gcd
    logic div_init;  // start reduction divisions
    logic div_step;  // one restoring division bit
    logic finish;    // form result
  } ctrl_t;

  typedef struct packed {
    logic early;     // result decided before gcd
    logic mul_done;
    logic gcd_done;
    logic div_done;
  } stat_t;
endpackage

// ----- rtl/core/rational_arithmetic_unit.sv -----
`timescale 1ns / 1ps
// Rational arithmetic unit: a/b op c/d with gcd reduction.
// Input channel in_valid/in_ready carries command and the four operands;
// output channel out_valid/out_ready carries the reduced numerator,
// positive denominator and status (0 ok, 1 zero denominator,
// 2 divide by zero, 3 out of range; 0/1 on any error).
// One request is worked at a time. Zero denominators and divide by zero are
// detected during the shift-add multiply and end the request after it; a zero
// result ends it after gcd setup; otherwise the shift-add multiply is followed
// by binary gcd on 65-bit magnitudes and paired restoring division.
// The gcd loop and the bit-serial dividers take most of the time. The next
// request can be taken in the cycle after the result is taken.
// The result waits in an output register until taken; a stalled receiver
// holds the unit, which takes no new request until the result drains.
// Reset (synchronous, active high) returns to idle and drops any result.
module rational_arithmetic_unit #(
  parameter int VALUE_WIDTH = rau_pkg::ValueWidth
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         command,
  input  logic signed [31:0] a_numerator,
  input  logic signed [31:0] a_denominator,
  input  logic signed [31:0] b_numerator,
  input  logic signed [31:0] b_denominator,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] result_numerator,
  output logic [30:0]        result_denominator,
  output logic [1:0]         status
);
  rau_pkg::ctrl_t ctrl;
  rau_pkg::stat_t stat;

  rau_control u_ctl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .ctrl, .stat
  );

  rau_datapath #(.VALUE_WIDTH(VALUE_WIDTH)) u_dp (
    .clk, .ctrl, .stat, .command, .a_numerator, .a_denominator,
    .b_numerator, .b_denominator, .result_numerator, .result_denominator, .status
  );

`include "rational_arithmetic_unit_assert.svh"
  `RAU_ASSERT_IMPL(a_no_accept_busy, out_valid, !in_ready)
  `RAU_ASSERT_IMPL(a_error_zero, out_valid && status != rau_pkg::ST_OK,
      result_numerator == 0 && result_denominator == 31'd1)
  `RAU_ASSERT_IMPL(a_den_nonzero, out_valid, result_denominator != 31'd0)
  `RAU_ASSERT_NEXT(a_result_held, out_valid && !out_ready, out_valid && $stable(result_numerator))
endmodule

// ----- rtl/core/rau_datapath.sv -----
`timescale 1ns / 1ps
module rau_datapath #(
  parameter int VALUE_WIDTH = rau_pkg::ValueWidth
) (
  input  logic                clk,
  input  rau_pkg::ctrl_t      ctrl,
  output rau_pkg::stat_t      stat,
  input  logic [1:0]          command,
  input  logic signed [31:0]  a_numerator,
  input  logic signed [31:0]  a_denominator,
  input  logic signed [31:0]  b_numerator,
  input  logic signed [31:0]  b_denominator,
  output logic signed [31:0]  result_numerator,
  output logic [30:0]         result_denominator,
  output logic [1:0]          status
);
  localparam int MW = rau_pkg::MagWidth;
  localparam int CW = $clog2(MW + 1);
  localparam logic [MW-1:0] Limit = {{(MW-VALUE_WIDTH+1){1'b0}}, {(VALUE_WIDTH-1){1'b1}}};

  logic [1:0] cmd;
  logic [32:0] m_an, m_ad, m_bn, m_bd;
  logic s_an, s_ad, s_bn, s_bd;
  // multiplier operands: three products run in parallel shift-add lanes
  logic [32:0] mq1, mq2, mq3;
  logic [MW-1:0] mc1, mc2, mc3, p1, p2, p3;
  logic [5:0] mcnt;
  logic s1, s2, nneg, dneg;
  logic [MW:0] nmag;
  logic [MW-1:0] dmag;
  logic [MW:0] gx, gy;
  logic [CW-1:0] shf;
  logic [MW:0] g;
  logic [MW:0] q1, r1, q2, r2;
  logic [6:0] dcnt;
  logic early;
  logic [1:0] early_st;

  function automatic logic [32:0] mag32(input logic [31:0] v);
    mag32 = v[31] ? (33'h100000000 - {1'b0, v}) : {1'b0, v};
  endfunction

  assign stat.early = early;
  assign stat.mul_done = (mcnt == 6'd33);
  assign stat.gcd_done = (gy == '0);
  assign stat.div_done = (dcnt == 7'(MW + 1));

  logic [MW:0] gsmall, gbig, gdiff;
  logic [MW+1:0] t1, t2;
  always_comb begin
    gsmall = (gx < gy) ? gx : gy;
    gbig = (gx < gy) ? gy : gx;
    gdiff = gbig - gsmall;
    t1 = {r1, q1[MW]} - {1'b0, g};
    t2 = {r2, q2[MW]} - {1'b0, g};
    s1 = s_an ^ s_bd;
    s2 = s_bn ^ s_ad ^ (cmd == rau_pkg::CMD_SUB);
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd <= command;
      s_an <= a_numerator[31]; m_an <= mag32(a_numerator);
      s_ad <= a_denominator[31]; m_ad <= mag32(a_denominator);
      s_bn <= b_numerator[31]; m_bn <= mag32(b_numerator);
      s_bd <= b_denominator[31]; m_bd <= mag32(b_denominator);
      mcnt <= '0;
      early <= 1'b0;
    end
    if (ctrl.mul_step) begin
      if (mcnt == 6'd0) begin
        // select operand pairs for the three products
        mq1 <= m_an;
        mc1 <= {31'd0, (cmd == rau_pkg::CMD_MUL) ? m_bn : m_bd};
        mq2 <= m_bn;
        mc2 <= {31'd0, m_ad};
        mq3 <= m_ad;
        mc3 <= {31'd0, (cmd == rau_pkg::CMD_DIV) ? m_bn : m_bd};
        p1 <= '0; p2 <= '0; p3 <= '0;
        if (m_ad == '0 || m_bd == '0) begin
          early <= 1'b1; early_st <= rau_pkg::ST_ZERO_DEN;
        end else if (cmd == rau_pkg::CMD_DIV && m_bn == '0) begin
          early <= 1'b1; early_st <= rau_pkg::ST_DIV_ZERO;
        end
      end else begin
        if (mq1[0]) p1 <= p1 + mc1;
        if (mq2[0]) p2 <= p2 + mc2;
        if (mq3[0]) p3 <= p3 + mc3;
        mq1 <= mq1 >> 1; mq2 <= mq2 >> 1; mq3 <= mq3 >> 1;
        mc1 <= mc1 << 1; mc2 <= mc2 << 1; mc3 <= mc3 << 1;
      end
      mcnt <= mcnt + 6'd1;
    end
    if (ctrl.add_step) begin
      dmag <= p3;
      case (cmd)
        rau_pkg::CMD_ADD, rau_pkg::CMD_SUB: begin
          dneg <= s_ad ^ s_bd;
          if (s1 == s2) begin
            nneg <= s1; nmag <= {1'b0, p1} + {1'b0, p2};
          end else if (p1 >= p2) begin
            nneg <= s1; nmag <= {1'b0, p1 - p2};
          end else begin
            nneg <= s2; nmag <= {1'b0, p2 - p1};
          end
        end
        rau_pkg::CMD_MUL: begin
          nneg <= s_an ^ s_bn; dneg <= s_ad ^ s_bd; nmag <= {1'b0, p1};
        end
        default: begin
          nneg <= s_an ^ s_bd; dneg <= s_ad ^ s_bn; nmag <= {1'b0, p1};
        end
      endcase
    end
    if (ctrl.gcd_init) begin
      gx <= nmag; gy <= {1'b0, dmag}; shf <= '0;
      if (nmag == '0) begin
        early <= 1'b1; early_st <= rau_pkg::ST_OK;
      end
    end
    if (ctrl.gcd_step) begin
      // binary gcd: strip common twos, then subtract
      if (!gx[0] && !gy[0]) begin
        gx <= gx >> 1; gy <= gy >> 1; shf <= shf + CW'(1);
      end else if (!gx[0]) gx <= gx >> 1;
      else if (!gy[0]) gy <= gy >> 1;
      else begin
        gx <= gsmall; gy <= gdiff;
      end
    end
    if (ctrl.div_init) begin
      g <= gx << shf;
      q1 <= nmag; r1 <= '0;
      q2 <= {1'b0, dmag}; r2 <= '0;
      dcnt <= '0;
    end
    if (ctrl.div_step) begin
      if (!t1[MW+1]) begin
        r1 <= t1[MW:0]; q1 <= {q1[MW-1:0], 1'b1};
      end else begin
        r1 <= {r1[MW-1:0], q1[MW]}; q1 <= {q1[MW-1:0], 1'b0};
      end
      if (!t2[MW+1]) begin
        r2 <= t2[MW:0]; q2 <= {q2[MW-1:0], 1'b1};
      end else begin
        r2 <= {r2[MW-1:0], q2[MW]}; q2 <= {q2[MW-1:0], 1'b0};
      end
      dcnt <= dcnt + 7'd1;
    end
    if (ctrl.finish) begin
      if (early) begin
        result_numerator <= '0; result_denominator <= 31'd1; status <= early_st;
      end else if (q1[MW:0] > {1'b0, Limit} || q2[MW:0] > {1'b0, Limit}) begin
        result_numerator <= '0; result_denominator <= 31'd1; status <= rau_pkg::ST_RANGE;
      end else begin
        result_numerator <= (nneg ^ dneg) ? -q1[31:0] : q1[31:0];
        result_denominator <= q2[30:0];
        status <= rau_pkg::ST_OK;
      end
    end
  end
endmodule

// ----- rtl/core/rau_control.sv -----
`timescale 1ns / 1ps
module rau_control (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output rau_pkg::ctrl_t  ctrl,
  input  rau_pkg::stat_t  stat
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_ADD  = 3'd2;
  localparam logic [2:0] S_GINI = 3'd3;
  localparam logic [2:0] S_GCD  = 3'd4;
  localparam logic [2:0] S_DINI = 3'd5;
  localparam logic [2:0] S_DIV  = 3'd6;
  localparam logic [2:0] S_FIN  = 3'd7;

  logic [2:0] state, state_next;
  logic out_valid_next;

  // one request at a time; the result register frees as soon as it is taken
  assign in_ready = (state == S_IDLE) && !out_valid;

  always_comb begin
    state_next = state;
    ctrl = '0;
    out_valid_next = out_valid && !out_ready;
    case (state)
      S_IDLE: if (in_valid && in_ready) begin
        ctrl.load = 1'b1; state_next = S_MUL;
      end
      S_MUL: begin
        ctrl.mul_step = 1'b1;
        if (stat.mul_done) state_next = S_ADD;
      end
      S_ADD: begin
        ctrl.add_step = 1'b1; state_next = stat.early ? S_FIN : S_GINI;
      end
      S_GINI: begin
        ctrl.gcd_init = 1'b1; state_next = S_GCD;
      end
      S_GCD: begin
        if (stat.early) state_next = S_FIN;
        else if (stat.gcd_done) state_next = S_DINI;
        else ctrl.gcd_step = 1'b1;
      end
      S_DINI: begin
        ctrl.div_init = 1'b1; state_next = S_DIV;
      end
      S_DIV: begin
        if (stat.div_done) state_next = S_FIN;
        else ctrl.div_step = 1'b1;
      end
      S_FIN: begin
        ctrl.finish = 1'b1; out_valid_next = 1'b1; state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      out_valid <= out_valid_next;
    end
  end
endmodule
